// ----- hdl/dqe_pkg.sv -----
// dqe_pkg: shared types and constants of the double-ended queue engine.
// Command and status codes, controller states and the result bundle.
// No dependencies.
package dqe_pkg;

    localparam int CMD_W = 3;
    localparam int IDX_W = 11;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int OCC_W = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ       = 3'd4,
        CMD_WRITE      = 3'd5,
        CMD_INSERT     = 3'd6,
        CMD_ERASE      = 3'd7
    } cmd_t;

    typedef enum logic [STS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_FILL,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [VAL_W-1:0]  data;
        logic [OCC_W-1:0]  occupancy;
    } res_t;

endpackage

// ----- hdl/double_ended_queue_engine_unit.sv -----
// double_ended_queue_engine_unit: bounded double-ended queue, top level.
// Depends on dqe_pkg, dqe_ram and dqe_ctrl.
//
// Use: the s_ channel takes one command per transfer (s_command, s_index,
// s_value); the m_ channel returns exactly one result per command
// (m_status, m_data, m_occupancy), in command order.
// Push, pop, read and write pass through capture, one element store
// access and result hand-over. Insert moves each element from the index
// on up one place, then writes the new element; erase moves each element
// above the index down one place. The single write port of the store sets
// that loop. m_valid rises when the output register takes the result.
// The output register frees the engine: a new command is taken while a
// result waits on m_ready; a further result then holds the engine until
// the output register is drained.
// Reset (synchronous, aresetn low) empties the queue and drops any result
// not yet transferred; no clearing pass is needed.
module double_ended_queue_engine_unit #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dqe_pkg::CMD_W-1:0]     s_command,
    input  logic [dqe_pkg::IDX_W-1:0]     s_index,
    input  logic [dqe_pkg::VAL_W-1:0]     s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dqe_pkg::STS_W-1:0]     m_status,
    output logic [dqe_pkg::VAL_W-1:0]     m_data,
    output logic [dqe_pkg::OCC_W-1:0]     m_occupancy
);

    localparam int AW = $clog2(DEPTH);

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    logic          res_valid, res_ready;
    dqe_pkg::res_t res;

    logic          m_valid_reg, m_valid_next;
    dqe_pkg::res_t out_reg, out_next;

    dqe_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dqe_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_index   (s_index),
        .s_value   (s_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output register: loads when empty or being drained in the same cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = out_reg.status;
    assign m_data      = out_reg.data;
    assign m_occupancy = out_reg.occupancy;

endmodule

// ----- hdl/dqe_ram.sv -----
// dqe_ram: element store, one write port and one read port, registered read.
// Read data holds while no read is issued.
// No dependencies.
module dqe_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/dqe_ctrl.sv -----
// dqe_ctrl: command sequencer of the queue engine; front pointer, count,
// and the shift loop for insert and erase over the element store.
// Depends on dqe_pkg; drives the ports of dqe_ram.
module dqe_ctrl #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dqe_pkg::CMD_W-1:0]    s_command,
    input  logic [dqe_pkg::IDX_W-1:0]    s_index,
    input  logic [dqe_pkg::VAL_W-1:0]    s_value,
    output logic                         res_valid,
    input  logic                         res_ready,
    output dqe_pkg::res_t                res,
    output logic                         ram_we,
    output logic [$clog2(DEPTH)-1:0]     ram_waddr,
    output logic [DATA_WIDTH-1:0]        ram_wdata,
    output logic                         ram_re,
    output logic [$clog2(DEPTH)-1:0]     ram_raddr,
    input  logic [DATA_WIDTH-1:0]        ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > dqe_pkg::IDX_W) ? CW : dqe_pkg::IDX_W;
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] BACK_C  = CW'(DEPTH - 1);

    dqe_pkg::state_t state_reg, state_next;
    dqe_pkg::cmd_t   cmd_reg, cmd_next;
    logic [dqe_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [DATA_WIDTH-1:0]     val_reg, val_next;
    logic [AW-1:0]             front_reg, front_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             cursor_reg, cursor_next;
    dqe_pkg::status_t          status_reg, status_next;
    logic                      from_mem_reg, from_mem_next;

    logic [CW-1:0] rd_off, wr_off;
    logic          wr_from_mem;
    logic          full, empty;
    logic [LW-1:0] idx_l, cnt_l;
    logic [CW-1:0] idx_c;

    // ring address: (front + offset) mod DEPTH, sum always below 2*DEPTH
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] f, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(f) + (CW + 1)'(off);
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);
    assign idx_l = LW'(idx_reg);
    assign cnt_l = LW'(count_reg);
    assign idx_c = CW'(idx_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dqe_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = dqe_pkg::S_EXEC;
                end
            end
            dqe_pkg::S_EXEC: begin
                state_next = dqe_pkg::S_RESP;
                case (cmd_reg)
                    dqe_pkg::CMD_INSERT: begin
                        if (idx_l <= cnt_l && !full && idx_c != count_reg) begin
                            state_next = dqe_pkg::S_SHIFT;
                        end
                    end
                    dqe_pkg::CMD_ERASE: begin
                        if (idx_l < cnt_l && (idx_c + CW'(1)) != count_reg) begin
                            state_next = dqe_pkg::S_SHIFT;
                        end
                    end
                    default: begin
                        state_next = dqe_pkg::S_RESP;
                    end
                endcase
            end
            dqe_pkg::S_SHIFT: begin
                if (cmd_reg == dqe_pkg::CMD_INSERT) begin
                    if (cursor_reg == idx_c) begin
                        state_next = dqe_pkg::S_FILL;
                    end
                end else if ((cursor_reg + CW'(1)) == count_reg) begin
                    state_next = dqe_pkg::S_RESP;
                end
            end
            dqe_pkg::S_FILL: begin
                state_next = dqe_pkg::S_RESP;
            end
            dqe_pkg::S_RESP: begin
                if (res_ready) begin
                    state_next = dqe_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dqe_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        status_next   = status_reg;
        from_mem_next = from_mem_reg;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        rd_off        = cursor_reg;
        wr_off        = idx_c;
        wr_from_mem   = 1'b0;
        case (state_reg)
            dqe_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd_next = dqe_pkg::cmd_t'(s_command);
                    idx_next = s_index;
                    val_next = DATA_WIDTH'(s_value);
                end
            end
            dqe_pkg::S_EXEC: begin
                status_next   = dqe_pkg::STAT_OK;
                from_mem_next = 1'b0;
                case (cmd_reg)
                    dqe_pkg::CMD_PUSH_BACK: begin
                        if (full) begin
                            status_next = dqe_pkg::STAT_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            wr_off     = count_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    dqe_pkg::CMD_PUSH_FRONT: begin
                        if (full) begin
                            status_next = dqe_pkg::STAT_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            wr_off     = BACK_C;
                            front_next = phys(front_reg, BACK_C);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    dqe_pkg::CMD_POP_BACK: begin
                        if (empty) begin
                            status_next = dqe_pkg::STAT_EMPTY;
                        end else begin
                            ram_re        = 1'b1;
                            rd_off        = count_reg - CW'(1);
                            count_next    = count_reg - CW'(1);
                            from_mem_next = 1'b1;
                        end
                    end
                    dqe_pkg::CMD_POP_FRONT: begin
                        if (empty) begin
                            status_next = dqe_pkg::STAT_EMPTY;
                        end else begin
                            ram_re        = 1'b1;
                            rd_off        = '0;
                            front_next    = phys(front_reg, CW'(1));
                            count_next    = count_reg - CW'(1);
                            from_mem_next = 1'b1;
                        end
                    end
                    dqe_pkg::CMD_READ: begin
                        if (idx_l >= cnt_l) begin
                            status_next = dqe_pkg::STAT_RANGE;
                        end else begin
                            ram_re        = 1'b1;
                            rd_off        = idx_c;
                            from_mem_next = 1'b1;
                        end
                    end
                    dqe_pkg::CMD_WRITE: begin
                        if (idx_l >= cnt_l) begin
                            status_next = dqe_pkg::STAT_RANGE;
                        end else begin
                            ram_we = 1'b1;
                            wr_off = idx_c;
                        end
                    end
                    dqe_pkg::CMD_INSERT: begin
                        if (idx_l > cnt_l) begin
                            status_next = dqe_pkg::STAT_RANGE;
                        end else if (full) begin
                            status_next = dqe_pkg::STAT_FULL;
                        end else if (idx_c == count_reg) begin
                            ram_we     = 1'b1;
                            wr_off     = idx_c;
                            count_next = count_reg + CW'(1);
                        end else begin
                            ram_re      = 1'b1;
                            rd_off      = count_reg - CW'(1);
                            cursor_next = count_reg - CW'(1);
                        end
                    end
                    dqe_pkg::CMD_ERASE: begin
                        if (idx_l >= cnt_l) begin
                            status_next = dqe_pkg::STAT_RANGE;
                        end else if ((idx_c + CW'(1)) == count_reg) begin
                            count_next = count_reg - CW'(1);
                        end else begin
                            ram_re      = 1'b1;
                            rd_off      = idx_c + CW'(1);
                            cursor_next = idx_c + CW'(1);
                        end
                    end
                    default: begin
                        status_next = dqe_pkg::STAT_OK;
                    end
                endcase
            end
            dqe_pkg::S_SHIFT: begin
                // element read last cycle moves one place; next read overlaps
                ram_we      = 1'b1;
                wr_from_mem = 1'b1;
                if (cmd_reg == dqe_pkg::CMD_INSERT) begin
                    wr_off = cursor_reg + CW'(1);
                    if (cursor_reg != idx_c) begin
                        ram_re      = 1'b1;
                        rd_off      = cursor_reg - CW'(1);
                        cursor_next = cursor_reg - CW'(1);
                    end
                end else begin
                    wr_off = cursor_reg - CW'(1);
                    if ((cursor_reg + CW'(1)) == count_reg) begin
                        count_next = count_reg - CW'(1);
                    end else begin
                        ram_re      = 1'b1;
                        rd_off      = cursor_reg + CW'(1);
                        cursor_next = cursor_reg + CW'(1);
                    end
                end
            end
            dqe_pkg::S_FILL: begin
                ram_we     = 1'b1;
                wr_off     = idx_c;
                count_next = count_reg + CW'(1);
            end
            dqe_pkg::S_RESP: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = phys(front_reg, rd_off);
    assign ram_waddr = phys(front_reg, wr_off);
    assign ram_wdata = wr_from_mem ? ram_rdata : val_reg;

    assign s_ready       = (state_reg == dqe_pkg::S_IDLE);
    assign res_valid     = (state_reg == dqe_pkg::S_RESP);
    assign res.status    = status_reg;
    assign res.data      = from_mem_reg ? dqe_pkg::VAL_W'(ram_rdata) : '0;
    assign res.occupancy = dqe_pkg::OCC_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dqe_pkg::S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        cursor_reg   <= cursor_next;
        status_reg   <= status_next;
        from_mem_reg <= from_mem_next;
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for double_ended_queue_engine_unit.
// Runs directed, random, full-queue, back-pressure and mixed-drain command streams against
// an in-bench ring model and compares every result. Depends on dqe_pkg and the engine RTL.
module testbench;

    localparam int RING_DEPTH  = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int EXP_DEPTH   = 64;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic [dqe_pkg::CMD_W-1:0]  s_command = '0;
    logic [dqe_pkg::IDX_W-1:0]  s_index   = '0;
    logic [dqe_pkg::VAL_W-1:0]  s_value   = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic [dqe_pkg::STS_W-1:0]  m_status;
    logic [dqe_pkg::VAL_W-1:0]  m_data;
    logic [dqe_pkg::OCC_W-1:0]  m_occupancy;

    // ring model state
    logic [dqe_pkg::VAL_W-1:0]  ring [RING_DEPTH];
    int unsigned       ring_head  = 0;
    int unsigned       ring_count = 0;
    int unsigned       peak_fill  = 0;

    dqe_pkg::res_t     exp_buf [EXP_DEPTH];
    int                exp_wr     = 0;
    int                exp_rd     = 0;
    int                n_issued   = 0;
    int                n_compared = 0;
    int                n_errors   = 0;
    int                burst_left = 1;
    int                hold_request = 0;
    int                hold_left  = 0;
    int                rx_mode    = 0;
    int                rx_mode_left = 0;
    logic [7:0]        rx_mask    = 8'b1011_0110;

    double_ended_queue_engine_unit #(
        .DEPTH      (RING_DEPTH),
        .DATA_WIDTH (dqe_pkg::VAL_W)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_index     (s_index),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_data      (m_data),
        .m_occupancy (m_occupancy)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned ring_slot(input int unsigned logical);
        return (ring_head + logical) % RING_DEPTH;
    endfunction

    function automatic void predict_result(input dqe_pkg::cmd_t op,
                                           input logic [dqe_pkg::IDX_W-1:0] idx,
                                           input logic [dqe_pkg::VAL_W-1:0] val,
                                           output dqe_pkg::res_t r);
        int unsigned k;
        int unsigned pos;
        pos = idx;
        r.status = dqe_pkg::STAT_OK;
        r.data   = '0;
        case (op)
            dqe_pkg::CMD_PUSH_BACK: begin
                if (ring_count >= RING_DEPTH) begin
                    r.status = dqe_pkg::STAT_FULL;
                end else begin
                    ring[ring_slot(ring_count)] = val;
                    ring_count++;
                end
            end
            dqe_pkg::CMD_PUSH_FRONT: begin
                if (ring_count >= RING_DEPTH) begin
                    r.status = dqe_pkg::STAT_FULL;
                end else begin
                    ring_head = (ring_head == 0) ? RING_DEPTH - 1 : ring_head - 1;
                    ring[ring_head] = val;
                    ring_count++;
                end
            end
            dqe_pkg::CMD_POP_BACK: begin
                if (ring_count == 0) begin
                    r.status = dqe_pkg::STAT_EMPTY;
                end else begin
                    ring_count--;
                    r.data = ring[ring_slot(ring_count)];
                end
            end
            dqe_pkg::CMD_POP_FRONT: begin
                if (ring_count == 0) begin
                    r.status = dqe_pkg::STAT_EMPTY;
                end else begin
                    r.data = ring[ring_head];
                    ring_head = ring_slot(1);
                    ring_count--;
                end
            end
            dqe_pkg::CMD_READ: begin
                if (pos >= ring_count) r.status = dqe_pkg::STAT_RANGE;
                else r.data = ring[ring_slot(pos)];
            end
            dqe_pkg::CMD_WRITE: begin
                if (pos >= ring_count) r.status = dqe_pkg::STAT_RANGE;
                else ring[ring_slot(pos)] = val;
            end
            dqe_pkg::CMD_INSERT: begin
                if (pos > ring_count) begin
                    r.status = dqe_pkg::STAT_RANGE;
                end else if (ring_count >= RING_DEPTH) begin
                    r.status = dqe_pkg::STAT_FULL;
                end else begin
                    for (k = ring_count; k > pos; k--)
                        ring[ring_slot(k)] = ring[ring_slot(k - 1)];
                    ring[ring_slot(pos)] = val;
                    ring_count++;
                end
            end
            default: begin
                if (pos >= ring_count) begin
                    r.status = dqe_pkg::STAT_RANGE;
                end else begin
                    for (k = pos; k + 1 < ring_count; k++)
                        ring[ring_slot(k)] = ring[ring_slot(k + 1)];
                    ring_count--;
                end
            end
        endcase
        r.occupancy = dqe_pkg::OCC_W'(ring_count);
        if (ring_count > peak_fill) peak_fill = ring_count;
    endfunction

    task automatic issue_command(input dqe_pkg::cmd_t op, input int unsigned idx,
                                 input logic [dqe_pkg::VAL_W-1:0] val);
        dqe_pkg::res_t want;
        predict_result(op, dqe_pkg::IDX_W'(idx), val, want);
        s_valid   <= 1'b1;
        s_command <= op;
        s_index   <= dqe_pkg::IDX_W'(idx);
        s_value   <= val;
        do @(posedge aclk); while (!s_ready);
        exp_buf[exp_wr % EXP_DEPTH] = want;
        exp_wr++;
        n_issued++;
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic stop_sending;
        if (s_valid) s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic flag_mismatch(input string msg);
        n_errors++;
        $display("testbench: mismatch at %0t ns: %s", $time, msg);
    endtask

    // receiver: own stall pattern plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left <= 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(64, 256);
            end
            rx_mode_left--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: begin
                    m_ready <= rx_mask[0];
                    rx_mask = {rx_mask[0], rx_mask[7:1]};
                end
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        dqe_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_rd == exp_wr) begin
                flag_mismatch("result transfer with no command outstanding");
            end else begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                n_compared++;
                if (m_status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", m_status, want.status));
                if (m_data !== want.data)
                    flag_mismatch($sformatf("data %h, expected %h", m_data, want.data));
                if (m_occupancy !== want.occupancy)
                    flag_mismatch($sformatf("occupancy %0d, expected %0d",
                                            m_occupancy, want.occupancy));
            end
        end
    end

    // watchdog: cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    task automatic test_edge_cases;
        issue_command(dqe_pkg::CMD_POP_BACK, 0, 32'h0);
        issue_command(dqe_pkg::CMD_POP_FRONT, 0, 32'h0);
        issue_command(dqe_pkg::CMD_ERASE, 0, 32'h0);
        issue_command(dqe_pkg::CMD_READ, 0, 32'h0);
        issue_command(dqe_pkg::CMD_WRITE, 0, 32'hFFFF_FFFF);
        issue_command(dqe_pkg::CMD_INSERT, 1, 32'h1);
        issue_command(dqe_pkg::CMD_INSERT, 2047, 32'h2);
        issue_command(dqe_pkg::CMD_INSERT, 0, 32'hFFFF_FFFF);
        issue_command(dqe_pkg::CMD_PUSH_FRONT, 0, 32'h0);
        issue_command(dqe_pkg::CMD_PUSH_BACK, 0, 32'hA5A5_5A5A);
        issue_command(dqe_pkg::CMD_READ, 0, 32'h0);
        issue_command(dqe_pkg::CMD_READ, 2, 32'h0);
        issue_command(dqe_pkg::CMD_READ, 3, 32'h0);
        issue_command(dqe_pkg::CMD_WRITE, 1, 32'h1234_5678);
        issue_command(dqe_pkg::CMD_READ, 1024, 32'h0);
        issue_command(dqe_pkg::CMD_INSERT, 3, 32'hDEAD_BEEF);
        issue_command(dqe_pkg::CMD_INSERT, 1, 32'h0F0F_0F0F);
        issue_command(dqe_pkg::CMD_ERASE, 2, 32'h0);
        issue_command(dqe_pkg::CMD_ERASE, 3, 32'h0);
        issue_command(dqe_pkg::CMD_POP_BACK, 0, 32'h0);
        issue_command(dqe_pkg::CMD_POP_FRONT, 0, 32'h0);
        issue_command(dqe_pkg::CMD_WRITE, 0, 32'h8000_0001);
        issue_command(dqe_pkg::CMD_READ, 1, 32'h0);
        issue_command(dqe_pkg::CMD_POP_FRONT, 0, 32'h0);
        stop_sending();
    endtask

    task automatic test_random_small(input int n_items);
        dqe_pkg::cmd_t op;
        int unsigned idx;
        int sel;
        repeat (n_items) begin
            op = dqe_pkg::cmd_t'($urandom_range(0, 7));
            if (ring_count > 40
                && op inside {dqe_pkg::CMD_PUSH_BACK, dqe_pkg::CMD_PUSH_FRONT,
                              dqe_pkg::CMD_INSERT}
                && $urandom_range(0, 1))
                op = $urandom_range(0, 1) ? dqe_pkg::CMD_POP_BACK : dqe_pkg::CMD_POP_FRONT;
            sel = $urandom_range(0, 9);
            if (sel <= 6) idx = $urandom_range(0, ring_count);
            else if (sel <= 8) idx = ring_count + $urandom_range(0, 3);
            else idx = $urandom_range(0, 2047);
            issue_command(op, idx, $urandom);
        end
        stop_sending();
    endtask

    task automatic test_fill_to_full;
        int unsigned back_off;
        while (ring_count < RING_DEPTH) begin
            case ($urandom_range(0, 9))
                0: begin
                    back_off = $urandom_range(0, (ring_count < 3) ? ring_count : 3);
                    issue_command(dqe_pkg::CMD_INSERT, ring_count - back_off, $urandom);
                end
                1, 2, 3, 4: issue_command(dqe_pkg::CMD_PUSH_FRONT, 0, $urandom);
                default:    issue_command(dqe_pkg::CMD_PUSH_BACK, 0, $urandom);
            endcase
        end
        issue_command(dqe_pkg::CMD_PUSH_BACK, 0, $urandom);
        issue_command(dqe_pkg::CMD_PUSH_FRONT, 0, $urandom);
        issue_command(dqe_pkg::CMD_INSERT, ring_count, $urandom);
        issue_command(dqe_pkg::CMD_INSERT, 0, $urandom);
        issue_command(dqe_pkg::CMD_INSERT, ring_count + 1, $urandom);
        issue_command(dqe_pkg::CMD_INSERT, 2047, $urandom);
        issue_command(dqe_pkg::CMD_READ, ring_count - 1, 32'h0);
        issue_command(dqe_pkg::CMD_READ, ring_count, 32'h0);
        issue_command(dqe_pkg::CMD_WRITE, 0, $urandom);
        issue_command(dqe_pkg::CMD_ERASE, ring_count - 1, 32'h0);
        issue_command(dqe_pkg::CMD_INSERT, 0, $urandom);
        issue_command(dqe_pkg::CMD_ERASE, 0, 32'h0);
        issue_command(dqe_pkg::CMD_PUSH_FRONT, 0, $urandom);
        stop_sending();
    endtask

    task automatic test_output_backpressure;
        hold_request = 400;
        repeat (40) begin
            if ($urandom_range(0, 1))
                issue_command(dqe_pkg::CMD_READ, $urandom_range(0, ring_count - 1), 0);
            else
                issue_command(dqe_pkg::CMD_WRITE, $urandom_range(0, ring_count - 1), $urandom);
        end
        stop_sending();
    endtask

    task automatic test_drain_mixed(input int n_items);
        int unsigned last_idx;
        repeat (n_items) begin
            last_idx = (ring_count == 0) ? 0 : ring_count - 1;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:     issue_command(dqe_pkg::CMD_POP_BACK, 0, 32'h0);
                7, 8, 9, 10, 11, 12, 13: issue_command(dqe_pkg::CMD_POP_FRONT, 0, 32'h0);
                14, 15: issue_command(dqe_pkg::CMD_READ, $urandom_range(0, last_idx), 32'h0);
                16: issue_command(dqe_pkg::CMD_WRITE, $urandom_range(0, last_idx), $urandom);
                17: issue_command(dqe_pkg::CMD_ERASE, last_idx - $urandom_range(0, 2), 32'h0);
                18: issue_command(dqe_pkg::CMD_INSERT, ring_count - $urandom_range(0, 2),
                                  $urandom);
                default: issue_command(dqe_pkg::CMD_READ, $urandom_range(0, 2047), 32'h0);
            endcase
        end
        stop_sending();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_cases();
        test_random_small(300);
        test_fill_to_full();
        test_output_backpressure();
        test_drain_mixed(300);
        while (exp_rd != exp_wr) @(posedge aclk);
        repeat (16) @(posedge aclk);
        $display("testbench: %0d commands issued, %0d results compared, peak occupancy %0d",
                 n_issued, n_compared, peak_fill);
        $display("testbench: all commands, empty/full/range cases, wrap and long output stall");
        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
